@@ rtl/assert_macros.svh @@
// assertion macros used by line_line_intersection
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define LLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, live during reset
`define LLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define LLI_ASSERT_NOW(lbl, ante, cons, msg)
`define LLI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/lli_pkg.sv @@
// widths and types of the line intersection datapath
`timescale 1ns / 1ps
package lli_pkg;
  localparam int IN_BITS    = 16;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 48;
  localparam int A_BITS = COORD_BITS + 1;       // line coefficients a, b
  localparam int C_BITS = 2 * COORD_BITS + 2;   // line coefficient c
  localparam int D_BITS = 2 * A_BITS + 1;       // determinant
  localparam int N_BITS = A_BITS + C_BITS + 1;  // numerators
  localparam int Q_BITS = N_BITS + FRAC_BITS;   // dividend bits, one cell each

  typedef logic signed [IN_BITS-1:0]  field_t;
  typedef logic signed [OUT_BITS-1:0] res_t;

  typedef struct packed {
    logic [D_BITS-1:0]   rem;
    logic [Q_BITS-1:0]   dv;
    logic [OUT_BITS-1:0] q;
    logic                hi;
  } lane_t;

  typedef struct packed {
    logic              found;
    logic              neg_x;
    logic              neg_y;
    logic [D_BITS-1:0] d;
    lane_t             lx;
    lane_t             ly;
  } cell_t;
endpackage

@@ rtl/lli_if.sv @@
// channel interfaces for line pairs and intersection results
`timescale 1ns / 1ps
interface lli_in_if;
  import lli_pkg::*;
  logic   valid;
  logic   ready;
  field_t first_begin_x;
  field_t first_begin_y;
  field_t first_end_x;
  field_t first_end_y;
  field_t second_begin_x;
  field_t second_begin_y;
  field_t second_end_x;
  field_t second_end_y;
  modport source(output valid, first_begin_x, first_begin_y, first_end_x, first_end_y,
                 second_begin_x, second_begin_y, second_end_x, second_end_y,
                 input ready);
  modport sink(input valid, first_begin_x, first_begin_y, first_end_x, first_end_y,
               second_begin_x, second_begin_y, second_end_x, second_end_y,
               output ready);
endinterface

interface lli_out_if;
  import lli_pkg::*;
  logic valid;
  logic ready;
  res_t cross_x;
  res_t cross_y;
  logic found;
  logic clipped;
  modport source(output valid, cross_x, cross_y, found, clipped, input ready);
  modport sink(input valid, cross_x, cross_y, found, clipped, output ready);
endinterface

@@ rtl/line_line_intersection.sv @@
// line pair intersection: six-stage front end, a row of divider cells, output register
// throughput: one line pair per cycle while out_ch.ready does not stall the chain
// each divider cell resolves one quotient bit
// backpressure ripples stage by stage, so bubbles are squeezed out while a result waits
// reset: synchronous active-low rst_n clears all valid flags; payload registers keep data
`timescale 1ns / 1ps
`include "assert_macros.svh"
module line_line_intersection (
  input  logic       clk,
  input  logic       rst_n,
  lli_in_if.sink     in_ch,
  lli_out_if.source  out_ch
);
  import lli_pkg::*;

  // chain links: index 0 is the front end, index k the output of cell k-1
  logic  [Q_BITS:0] ch_valid;
  logic  [Q_BITS:0] ch_ready;
  cell_t            ch_data [Q_BITS+1];

  // output register
  logic ov_r;
  res_t cx_r;
  res_t cy_r;
  logic found_r;
  logic clip_r;

  res_t val_x, val_y;
  logic clip_x, clip_y;
  logic out_adv;

  lli_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (ch_valid[0]),
    .out_ready (ch_ready[0]),
    .out_data  (ch_data[0])
  );

  // one cell per dividend bit, most significant first
  for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
    lli_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[g]),
      .in_ready  (ch_ready[g]),
      .in_data   (ch_data[g]),
      .out_valid (ch_valid[g+1]),
      .out_ready (ch_ready[g+1]),
      .out_data  (ch_data[g+1])
    );
  end

  // sign and saturation of one quotient; hi means bits beyond the field were set
  function automatic logic [OUT_BITS:0] finish(lane_t l, logic neg);
    logic [OUT_BITS-1:0] lim;
    logic [OUT_BITS-1:0] qv;
    logic                clip;
    lim = {1'b1, {(OUT_BITS-1){1'b0}}};
    if (neg) begin
      clip = l.hi || (l.q[OUT_BITS-1] && (l.q[OUT_BITS-2:0] != '0));
      qv   = clip ? lim : l.q;
      qv   = OUT_BITS'(-qv);
    end else begin
      clip = l.hi || l.q[OUT_BITS-1];
      qv   = clip ? ~lim : l.q;
    end
    return {clip, qv};
  endfunction

  always_comb begin
    {clip_x, val_x} = finish(ch_data[Q_BITS].lx, ch_data[Q_BITS].neg_x);
    {clip_y, val_y} = finish(ch_data[Q_BITS].ly, ch_data[Q_BITS].neg_y);
  end

  assign out_adv          = !ov_r || out_ch.ready;
  assign ch_ready[Q_BITS] = out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_adv) begin
      ov_r <= ch_valid[Q_BITS];
    end
  end

  // parallel or degenerate pairs come out as all zero
  always_ff @(posedge clk) begin
    if (out_adv) begin
      found_r <= ch_data[Q_BITS].found;
      cx_r    <= ch_data[Q_BITS].found ? val_x : '0;
      cy_r    <= ch_data[Q_BITS].found ? val_y : '0;
      clip_r  <= ch_data[Q_BITS].found && (clip_x || clip_y);
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.cross_x = cx_r;
  assign out_ch.cross_y = cy_r;
  assign out_ch.found   = found_r;
  assign out_ch.clipped = clip_r;

  `LLI_ASSERT_NOW(a_none_zero, ov_r && !found_r, cx_r == '0 && cy_r == '0 && !clip_r, "no-crossing result not zero")
  `LLI_ASSERT_NOW(a_clip_found, ov_r && clip_r, found_r, "clipped without a crossing")
  `LLI_ASSERT_NEXT(a_reset_idle, !rst_n, !ov_r && ch_valid == '0, "valid flags survive reset")
endmodule

@@ rtl/lli_front.sv @@
// coefficient, determinant and numerator pipeline ahead of the divider cells
`timescale 1ns / 1ps
module lli_front (
  input  logic          clk,
  input  logic          rst_n,
  lli_in_if.sink        in_ch,
  output logic          out_valid,
  input  logic          out_ready,
  output lli_pkg::cell_t out_data
);
  import lli_pkg::*;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [A_BITS-1:0]     av_t;
  typedef logic signed [2*COORD_BITS:0] mv_t;
  typedef logic signed [2*A_BITS-1:0]   ev_t;
  typedef logic signed [C_BITS-1:0]     cv_t;
  typedef logic signed [D_BITS-1:0]     dv_t;
  typedef logic signed [N_BITS-1:0]     nv_t;
  typedef logic signed [A_BITS+C_BITS-1:0] pv_t;

  logic [5:0] v_r;
  logic [5:0] adv;

  // stage 1: coordinates
  crd_t p1x_r, p1y_r, p2x_r, p2y_r, q1x_r, q1y_r, q2x_r, q2y_r;
  // stage 2: coefficients a, b and x run
  av_t a1_r, b1_r, a2_r, b2_r, dx1_r, dx2_r;
  crd_t x1_r, y1_r, x2_r, y2_r;
  // stage 3: products
  mv_t m11_r, m12_r, m21_r, m22_r;
  ev_t e1_r, e2_r;
  av_t a1s_r, b1s_r, a2s_r, b2s_r;
  // stage 4: c and determinant
  cv_t c1_r, c2_r;
  dv_t det4_r;
  av_t a1t_r, b1t_r, a2t_r, b2t_r;
  // stage 5: numerator products
  pv_t px1_r, px2_r, py1_r, py2_r;
  dv_t det5_r;
  // stage 6: magnitudes into the divider
  cell_t o_r;

  nv_t nx, ny;

  always_comb begin
    adv[5] = !v_r[5] || out_ready;
    for (int k = 4; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];
  assign out_valid   = v_r[5];
  assign out_data    = o_r;

  assign nx = nv_t'(px1_r) - nv_t'(px2_r);
  assign ny = nv_t'(py1_r) - nv_t'(py2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1x_r <= crd_t'(in_ch.first_begin_x[COORD_BITS-1:0]);
      p1y_r <= crd_t'(in_ch.first_begin_y[COORD_BITS-1:0]);
      p2x_r <= crd_t'(in_ch.first_end_x[COORD_BITS-1:0]);
      p2y_r <= crd_t'(in_ch.first_end_y[COORD_BITS-1:0]);
      q1x_r <= crd_t'(in_ch.second_begin_x[COORD_BITS-1:0]);
      q1y_r <= crd_t'(in_ch.second_begin_y[COORD_BITS-1:0]);
      q2x_r <= crd_t'(in_ch.second_end_x[COORD_BITS-1:0]);
      q2y_r <= crd_t'(in_ch.second_end_y[COORD_BITS-1:0]);
    end
    if (adv[1]) begin
      a1_r  <= av_t'(p2y_r) - av_t'(p1y_r);
      b1_r  <= av_t'(p1x_r) - av_t'(p2x_r);
      dx1_r <= av_t'(p2x_r) - av_t'(p1x_r);
      a2_r  <= av_t'(q2y_r) - av_t'(q1y_r);
      b2_r  <= av_t'(q1x_r) - av_t'(q2x_r);
      dx2_r <= av_t'(q2x_r) - av_t'(q1x_r);
      x1_r  <= p1x_r;
      y1_r  <= p1y_r;
      x2_r  <= q1x_r;
      y2_r  <= q1y_r;
    end
    if (adv[2]) begin
      m11_r <= mv_t'(y1_r) * mv_t'(dx1_r);
      m12_r <= mv_t'(x1_r) * mv_t'(a1_r);
      m21_r <= mv_t'(y2_r) * mv_t'(dx2_r);
      m22_r <= mv_t'(x2_r) * mv_t'(a2_r);
      e1_r  <= ev_t'(a1_r) * ev_t'(b2_r);
      e2_r  <= ev_t'(a2_r) * ev_t'(b1_r);
      a1s_r <= a1_r;
      b1s_r <= b1_r;
      a2s_r <= a2_r;
      b2s_r <= b2_r;
    end
    if (adv[3]) begin
      c1_r   <= cv_t'(m11_r) - cv_t'(m12_r);
      c2_r   <= cv_t'(m21_r) - cv_t'(m22_r);
      det4_r <= dv_t'(e1_r) - dv_t'(e2_r);
      a1t_r  <= a1s_r;
      b1t_r  <= b1s_r;
      a2t_r  <= a2s_r;
      b2t_r  <= b2s_r;
    end
    if (adv[4]) begin
      px1_r  <= pv_t'(b1t_r) * pv_t'(c2_r);
      px2_r  <= pv_t'(b2t_r) * pv_t'(c1_r);
      py1_r  <= pv_t'(a2t_r) * pv_t'(c1_r);
      py2_r  <= pv_t'(a1t_r) * pv_t'(c2_r);
      det5_r <= det4_r;
    end
    if (adv[5]) begin
      o_r.found <= (det5_r != '0);
      o_r.neg_x <= nx[N_BITS-1] ^ det5_r[D_BITS-1];
      o_r.neg_y <= ny[N_BITS-1] ^ det5_r[D_BITS-1];
      o_r.d     <= det5_r[D_BITS-1] ? D_BITS'(-det5_r) : D_BITS'(det5_r);
      o_r.lx.rem <= '0;
      o_r.lx.q   <= '0;
      o_r.lx.hi  <= 1'b0;
      o_r.lx.dv  <= Q_BITS'(nx[N_BITS-1] ? N_BITS'(-nx) : N_BITS'(nx)) << FRAC_BITS;
      o_r.ly.rem <= '0;
      o_r.ly.q   <= '0;
      o_r.ly.hi  <= 1'b0;
      o_r.ly.dv  <= Q_BITS'(ny[N_BITS-1] ? N_BITS'(-ny) : N_BITS'(ny)) << FRAC_BITS;
    end
  end
endmodule

@@ rtl/lli_cell.sv @@
// one restoring division cell: one quotient bit per lane per transfer
`timescale 1ns / 1ps
module lli_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lli_pkg::cell_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lli_pkg::cell_t out_data
);
  import lli_pkg::*;

  logic  v_r;
  cell_t d_r;
  cell_t d_nxt;

  function automatic lane_t step(lane_t l, logic [D_BITS-1:0] d);
    logic [D_BITS:0] sh;
    logic            bit_q;
    lane_t           r;
    sh    = {l.rem, l.dv[Q_BITS-1]};
    bit_q = (sh >= {1'b0, d});
    r.rem = bit_q ? D_BITS'(sh - {1'b0, d}) : sh[D_BITS-1:0];
    r.dv  = l.dv << 1;
    r.q   = {l.q[OUT_BITS-2:0], bit_q};
    r.hi  = l.hi | l.q[OUT_BITS-1];
    return r;
  endfunction

  always_comb begin
    d_nxt    = in_data;
    d_nxt.lx = step(in_data.lx, in_data.d);
    d_nxt.ly = step(in_data.ly, in_data.d);
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end
endmodule
